FILE: rtl/embedding_bag_sum_defines.svh
// Assertion macros for the checker of the embedding-bag sum engine.
`ifndef EMBEDDING_BAG_SUM_DEFINES_SVH
`define EMBEDDING_BAG_SUM_DEFINES_SVH

// Plain property sampled on clk, off during reset.
`define EBS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Condition this cycle implies consequence next cycle.
`define EBS_ASSERT_NEXT(label, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`endif

FILE: rtl/ebs_pkg.sv
// Shared types and constants of the embedding-bag sum engine.
package ebs_pkg;

    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_ADD   = 2'd1;
    localparam logic [1:0] MODE_EMIT  = 2'd2;

    localparam logic REG_ROW_LENGTH  = 1'b0;
    localparam logic REG_ROWS_IN_USE = 1'b1;

    localparam int LEN_W      = 7;
    localparam int ROWS_W     = 13;
    localparam int ROW_W      = 12;
    localparam int COL_PORT_W = 6;
    localparam int VALUE_W    = 16;
    localparam int SUM_W      = 32;
    localparam int ADDR_W     = 3;
    localparam int DATA_W     = 32;

    localparam logic [LEN_W-1:0]  ROW_LENGTH_RST  = 7'd64;
    localparam logic [ROWS_W-1:0] ROWS_IN_USE_RST = 13'd4096;

    typedef struct packed {
        logic tbl_write;
        logic latch_row;
        logic set_bad;
        logic col_clr;
        logic col_inc;
        logic acc_rd;
        logic out_load;
        logic bag_clear;
    } cmd_t;

    typedef struct packed {
        logic idx_bad;
        logic col_last;
        logic out_free;
    } status_t;

endpackage

FILE: rtl/embedding_bag_sum.sv
// Embedding-bag sum engine: top level with APB register port.
// A table write request, an out-of-range index or an unused mode leaves the controller idle.
// An index request for N active columns (row_length clamped to 1..MAX_DIM) steps through S_ACC:
// the weight table RAM gives one element per cycle, followed by the last write-back in S_DRAIN.
// An end-of-bag request passes the accept cycle, then an accumulator read and a result load per
// column, and stalls while a result waits with out_ready low; the last result may still wait in
// the output register while the next request is taken. The accumulator clears at once
// through per-column valid bits, so there is no clearing pass after reset. The weight table
// holds undefined data until written. Registers: row_length at 0x0, rows_in_use at 0x4.
module embedding_bag_sum #(
    parameter int TABLE_ROWS = 4096,
    parameter int MAX_DIM    = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ebs_pkg::ADDR_W-1:0]         paddr,
    input  logic [ebs_pkg::DATA_W-1:0]         pwdata,
    output logic [ebs_pkg::DATA_W-1:0]         prdata,
    output logic                               pready,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [1:0]                         mode,
    input  logic [ebs_pkg::ROW_W-1:0]          row,
    input  logic [ebs_pkg::COL_PORT_W-1:0]     column,
    input  logic signed [ebs_pkg::VALUE_W-1:0] value,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [ebs_pkg::COL_PORT_W-1:0]     out_column,
    output logic signed [ebs_pkg::SUM_W-1:0]   sum,
    output logic                               last,
    output logic                               bad_index,
    output logic                               saturated
);

    ebs_pkg::cmd_t              cmd;
    ebs_pkg::status_t           status;
    logic                       cfg_we;
    logic [ebs_pkg::LEN_W-1:0]  row_length;
    logic [ebs_pkg::ROWS_W-1:0] rows_in_use;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == ebs_pkg::REG_ROWS_IN_USE) ? ebs_pkg::DATA_W'(rows_in_use)
                                                           : ebs_pkg::DATA_W'(row_length);

    ebs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .mode     (mode),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    ebs_datapath #(
        .TABLE_ROWS (TABLE_ROWS),
        .MAX_DIM    (MAX_DIM)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg_we      (cfg_we),
        .cfg_idx     (paddr[2]),
        .cfg_wdata   (pwdata),
        .row_length  (row_length),
        .rows_in_use (rows_in_use),
        .row         (row),
        .column      (column),
        .value       (value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_column  (out_column),
        .sum         (sum),
        .last        (last),
        .bad_index   (bad_index),
        .saturated   (saturated)
    );

endmodule

FILE: rtl/ebs_ram.sv
// Generic simple dual-port RAM with registered read.
module ebs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/ebs_ctrl.sv
// Controller state machine: request decode and column sequencing.
module ebs_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [1:0]       mode,
    output logic             in_ready,
    input  ebs_pkg::status_t status,
    output ebs_pkg::cmd_t    cmd
);

    typedef enum logic [4:0] {
        S_IDLE    = 5'b00001,
        S_ACC     = 5'b00010,
        S_DRAIN   = 5'b00100,
        S_EMIT_RD = 5'b01000,
        S_EMIT_LD = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (mode)
                        ebs_pkg::MODE_WRITE:
                        begin
                            cmd.tbl_write = 1'b1;
                        end
                        ebs_pkg::MODE_ADD:
                        begin
                            if (status.idx_bad)
                            begin
                                cmd.set_bad = 1'b1;
                            end
                            else
                            begin
                                cmd.latch_row = 1'b1;
                                cmd.col_clr   = 1'b1;
                                state_next    = S_ACC;
                            end
                        end
                        ebs_pkg::MODE_EMIT:
                        begin
                            cmd.col_clr = 1'b1;
                            state_next  = S_EMIT_RD;
                        end
                        default:
                        begin
                            // unused mode: drop the request
                        end
                    endcase
                end
            end
            S_ACC:
            begin
                cmd.acc_rd = 1'b1;
                if (status.col_last)
                begin
                    cmd.col_clr = 1'b1;
                    state_next  = S_DRAIN;
                end
                else
                begin
                    cmd.col_inc = 1'b1;
                end
            end
            S_DRAIN:
            begin
                // last column write-back completes here
                state_next = S_IDLE;
            end
            S_EMIT_RD:
            begin
                state_next = S_EMIT_LD;
            end
            S_EMIT_LD:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    if (status.col_last)
                    begin
                        cmd.bag_clear = 1'b1;
                        cmd.col_clr   = 1'b1;
                        state_next    = S_IDLE;
                    end
                    else
                    begin
                        cmd.col_inc = 1'b1;
                        state_next  = S_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/ebs_datapath.sv
// Datapath: config registers, weight table, row accumulator and result register.
module ebs_datapath #(
    parameter int TABLE_ROWS = 4096,
    parameter int MAX_DIM    = 64
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  ebs_pkg::cmd_t                         cmd,
    output ebs_pkg::status_t                      status,
    input  logic                                  cfg_we,
    input  logic                                  cfg_idx,
    input  logic [ebs_pkg::DATA_W-1:0]            cfg_wdata,
    output logic [ebs_pkg::LEN_W-1:0]             row_length,
    output logic [ebs_pkg::ROWS_W-1:0]            rows_in_use,
    input  logic [ebs_pkg::ROW_W-1:0]             row,
    input  logic [ebs_pkg::COL_PORT_W-1:0]        column,
    input  logic signed [ebs_pkg::VALUE_W-1:0]    value,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [ebs_pkg::COL_PORT_W-1:0]        out_column,
    output logic signed [ebs_pkg::SUM_W-1:0]      sum,
    output logic                                  last,
    output logic                                  bad_index,
    output logic                                  saturated
);

    localparam int COL_W       = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int TABLE_DEPTH = TABLE_ROWS * MAX_DIM;
    localparam int TA_W        = $clog2(TABLE_DEPTH);
    localparam logic [COL_W-1:0] LAST_MAX = COL_W'(MAX_DIM - 1);

    logic [ebs_pkg::LEN_W-1:0]  row_length_reg;
    logic [ebs_pkg::ROWS_W-1:0] rows_in_use_reg;
    logic [COL_W-1:0]           col_reg;
    logic [COL_W-1:0]           col_next;
    logic [TA_W-1:0]            base_reg;
    logic                       p_valid_reg;
    logic [COL_W-1:0]           p_col_reg;
    logic [MAX_DIM-1:0]         acc_valid_reg;
    logic [MAX_DIM-1:0]         acc_valid_next;
    logic                       rd_vld_reg;
    logic                       bad_reg;
    logic                       sat_reg;
    logic                       out_valid_reg;
    logic [ebs_pkg::COL_PORT_W-1:0] out_column_reg;
    logic [ebs_pkg::SUM_W-1:0]  sum_reg;
    logic                       last_reg;
    logic                       bad_out_reg;
    logic                       sat_out_reg;

    logic [COL_W-1:0]           n_last;
    logic                       wr_ok;
    logic [TA_W-1:0]            tbl_waddr;
    logic [TA_W-1:0]            tbl_raddr;
    logic [ebs_pkg::VALUE_W-1:0] tbl_rdata;
    logic [ebs_pkg::SUM_W-1:0]  acc_rdata;
    logic [ebs_pkg::SUM_W-1:0]  acc_old;
    logic [ebs_pkg::SUM_W:0]    sum_wide;
    logic                       ovf;
    logic [ebs_pkg::SUM_W-1:0]  acc_wdata;

    // active column count minus one, clamped to the table width
    always_comb
    begin
        if (row_length_reg == '0)
        begin
            n_last = '0;
        end
        else if (32'(row_length_reg) > 32'(MAX_DIM))
        begin
            n_last = LAST_MAX;
        end
        else
        begin
            n_last = COL_W'(row_length_reg - 7'd1);
        end
    end

    assign status.col_last = (col_reg == n_last);
    assign status.idx_bad  = (13'(row) >= rows_in_use_reg)
                          || (32'(row) >= 32'(TABLE_ROWS));
    assign status.out_free = !out_valid_reg || out_ready;

    assign wr_ok     = (32'(row) < 32'(TABLE_ROWS)) && (32'(column) < 32'(MAX_DIM));
    assign tbl_waddr = TA_W'(32'(row) * 32'(MAX_DIM) + 32'(column));
    assign tbl_raddr = base_reg + TA_W'(col_reg);

    ebs_ram #(
        .WIDTH (ebs_pkg::VALUE_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (cmd.tbl_write && wr_ok),
        .waddr (tbl_waddr),
        .wdata (value),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    // saturating add of the table element into the column sum
    assign acc_old  = rd_vld_reg ? acc_rdata : '0;
    assign sum_wide = {acc_old[ebs_pkg::SUM_W-1], acc_old}
                    + {{(ebs_pkg::SUM_W - ebs_pkg::VALUE_W + 1){tbl_rdata[ebs_pkg::VALUE_W-1]}},
                       tbl_rdata};
    assign ovf      = sum_wide[ebs_pkg::SUM_W] ^ sum_wide[ebs_pkg::SUM_W-1];
    assign acc_wdata = !ovf ? sum_wide[ebs_pkg::SUM_W-1:0]
                     : (sum_wide[ebs_pkg::SUM_W] ? 32'h8000_0000 : 32'h7FFF_FFFF);

    ebs_ram #(
        .WIDTH (ebs_pkg::SUM_W),
        .DEPTH (MAX_DIM)
    ) u_acc (
        .clk   (clk),
        .we    (p_valid_reg),
        .waddr (p_col_reg),
        .wdata (acc_wdata),
        .raddr (col_reg),
        .rdata (acc_rdata)
    );

    always_comb
    begin
        col_next = col_reg;
        if (cmd.col_clr)
        begin
            col_next = '0;
        end
        else if (cmd.col_inc)
        begin
            col_next = col_reg + 1'b1;
        end
    end

    always_comb
    begin
        acc_valid_next = acc_valid_reg;
        if (cmd.bag_clear)
        begin
            acc_valid_next = '0;
        end
        else if (p_valid_reg)
        begin
            acc_valid_next[p_col_reg] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_length_reg  <= ebs_pkg::ROW_LENGTH_RST;
            rows_in_use_reg <= ebs_pkg::ROWS_IN_USE_RST;
            col_reg         <= '0;
            p_valid_reg     <= 1'b0;
            acc_valid_reg   <= '0;
            rd_vld_reg      <= 1'b0;
            bad_reg         <= 1'b0;
            sat_reg         <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_idx == ebs_pkg::REG_ROW_LENGTH)
                begin
                    row_length_reg <= cfg_wdata[ebs_pkg::LEN_W-1:0];
                end
                else
                begin
                    rows_in_use_reg <= cfg_wdata[ebs_pkg::ROWS_W-1:0];
                end
            end
            col_reg       <= col_next;
            p_valid_reg   <= cmd.acc_rd;
            acc_valid_reg <= acc_valid_next;
            rd_vld_reg    <= acc_valid_reg[col_reg];
            if (cmd.bag_clear)
            begin
                bad_reg <= 1'b0;
                sat_reg <= 1'b0;
            end
            else
            begin
                if (cmd.set_bad)
                begin
                    bad_reg <= 1'b1;
                end
                if (p_valid_reg && ovf)
                begin
                    sat_reg <= 1'b1;
                end
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        p_col_reg <= col_reg;
        if (cmd.latch_row)
        begin
            base_reg <= TA_W'(32'(row) * 32'(MAX_DIM));
        end
        if (cmd.out_load)
        begin
            out_column_reg <= ebs_pkg::COL_PORT_W'(col_reg);
            sum_reg        <= rd_vld_reg ? acc_rdata : '0;
            last_reg       <= status.col_last;
            bad_out_reg    <= bad_reg;
            sat_out_reg    <= sat_reg;
        end
    end

    assign row_length  = row_length_reg;
    assign rows_in_use = rows_in_use_reg;
    assign out_valid   = out_valid_reg;
    assign out_column  = out_column_reg;
    assign sum         = sum_reg;
    assign last        = last_reg;
    assign bad_index   = bad_out_reg;
    assign saturated   = sat_out_reg;

endmodule

FILE: rtl/ebs_checker.sv
// Port-level checker for the embedding-bag sum engine, bound to the top level.
`include "embedding_bag_sum_defines.svh"

module ebs_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_valid,
    input logic                               in_ready,
    input logic [1:0]                         mode,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic [ebs_pkg::COL_PORT_W-1:0]     out_column,
    input logic signed [ebs_pkg::SUM_W-1:0]   sum,
    input logic                               last
);

    logic wr_fire;
    logic emit_fire;
    logic mid_row;
    logic out_wait;
    logic [ebs_pkg::COL_PORT_W+ebs_pkg::SUM_W:0] out_word;

    assign wr_fire   = in_valid && in_ready && (mode == ebs_pkg::MODE_WRITE);
    assign emit_fire = in_valid && in_ready && (mode == ebs_pkg::MODE_EMIT);
    assign mid_row   = out_valid && !last;
    assign out_wait  = out_valid && !out_ready;
    assign out_word  = {out_column, sum, last};

    // a table write frees the input at once
    `EBS_ASSERT_NEXT(a_write_one_cycle, wr_fire, in_ready, "table write held the input")
    // an end-of-bag request holds off new requests while emitting
    `EBS_ASSERT_NEXT(a_emit_busy, emit_fire, !in_ready, "request taken during emit")
    // while a non-final column waits, the row is still being emitted
    `EBS_ASSERT(a_row_in_flight, !mid_row || !in_ready, "input ready before final column")
    // a stalled result holds
    `EBS_ASSERT_NEXT(a_out_hold, out_wait, out_valid && $stable(out_word), "stalled result changed")

endmodule

bind embedding_bag_sum ebs_checker u_ebs_checker (.*);
